// ----- design/prbf_pkg.sv -----
// prbf_pkg: shared types, constants and helper functions of the packet
// repetition budget filter. No dependencies; imported by every other design file.
package prbf_pkg;

	localparam int WINDOW_DEF  = 64;
	localparam int TAIL_LEN    = 16;
	localparam int CNT_W       = 7;
	localparam int SUM_W       = 13;
	localparam int POS_W       = 8;
	localparam int MATCH_W     = 5;
	localparam int EX_W        = 17;
	localparam int PROD_W      = EX_W + 32;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int MOD_SHIFT   = 37;

	localparam logic [POS_W-1:0]   REF_POS    = 8'd64;
	localparam logic [POS_W-1:0]   MATCH_END  = 8'd80;
	localparam logic [POS_W-1:0]   POS_MAX    = 8'd255;
	localparam logic [MATCH_W-1:0] REPEAT_MIN = 5'd14;
	localparam logic [31:0]        SEED       = 32'hDEADBEEF;
	localparam logic [7:0]         MOD_BASE   = 8'd100;
	localparam logic [31:0]        MOD_RECIP  = 32'h51EB851F;
	localparam logic [6:0]         RATE_LOW   = 7'd5;
	localparam logic [6:0]         RATE_HALF  = 7'd50;
	localparam logic [3:0]         DRAIN_MUL  = 4'd10;
	localparam logic [15:0]        RUN_MAX    = 16'hFFFF;

	// verdict codes
	localparam logic [2:0] V_SHORT  = 3'd0;
	localparam logic [2:0] V_REPEAT = 3'd1;
	localparam logic [2:0] V_SKIP   = 3'd2;
	localparam logic [2:0] V_CLEAN  = 3'd3;
	localparam logic [2:0] V_ANOM   = 3'd4;

	// register indexes
	localparam logic [2:0] R_LVL1    = 3'd0;
	localparam logic [2:0] R_LVL2    = 3'd1;
	localparam logic [2:0] R_LVL3    = 3'd2;
	localparam logic [2:0] R_CEIL    = 3'd3;
	localparam logic [2:0] R_REFILL  = 3'd4;
	localparam logic [2:0] R_PENALTY = 3'd5;
	localparam logic [2:0] R_SCORE   = 3'd6;
	localparam logic [2:0] R_STREAK  = 3'd7;

	typedef struct packed {
		logic [31:0]      lvl1;
		logic [31:0]      lvl2;
		logic [31:0]      lvl3;
		logic [31:0]      ceiling;
		logic [31:0]      refill;
		logic [31:0]      penalty;
		logic [SUM_W-1:0] score_thr;
		logic [15:0]      streak_thr;
	} cfg_t;

	localparam cfg_t CFG_RST = '{
		lvl1: 32'd4915200, lvl2: 32'd3276800, lvl3: 32'd1638400,
		ceiling: 32'd6553600, refill: 32'd65536, penalty: 32'd327680,
		score_thr: 13'd400, streak_thr: 16'd10};

	// per-packet summary handed from the front to the back
	typedef struct packed {
		logic             short_pkt;
		logic             repeat_run;
		logic [SUM_W-1:0] best;
	} summary_t;

	function automatic logic [1:0] level_of(input logic [31:0] b, input cfg_t c);
		logic [1:0] l;
		if (b > c.lvl1)      l = 2'd0;
		else if (b > c.lvl2) l = 2'd1;
		else if (b > c.lvl3) l = 2'd2;
		else                 l = 2'd3;
		return l;
	endfunction

	function automatic logic [31:0] xorshift(input logic [31:0] s);
		logic [31:0] x;
		x = s ^ (s << 13);
		x = x ^ (x >> 17);
		x = x ^ (x << 5);
		return x;
	endfunction

endpackage

// ----- design/prbf_front.sv -----
// prbf_front: byte intake, histogram and window score, repeat matching.
// Emits one summary per packet. Depends on prbf_pkg.
module prbf_front #(
	parameter int WINDOW = prbf_pkg::WINDOW_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     data_byte,
	input  logic                           last_byte,
	input  logic [prbf_pkg::SUM_W-1:0]     score_thr,
	output logic                           q_push,
	output prbf_pkg::summary_t             q_data,
	input  logic                           q_full
);
	import prbf_pkg::*;

	localparam int SLOT_W = $clog2(WINDOW);
	localparam logic [POS_W-1:0] WIN_P   = POS_W'(WINDOW);
	localparam logic [POS_W-1:0] WIN_END = POS_W'(WINDOW + TAIL_LEN);

	localparam logic [3:0] ST_INIT = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_OLD1 = 4'd2;
	localparam logic [3:0] ST_OLD2 = 4'd3;
	localparam logic [3:0] ST_NEW1 = 4'd4;
	localparam logic [3:0] ST_NEW2 = 4'd5;
	localparam logic [3:0] ST_PUSH = 4'd6;
	localparam logic [3:0] ST_CLR  = 4'd7;
	localparam logic [3:0] ST_CLRW = 4'd8;

	logic [CNT_W-1:0] cnt_mem [256];
	logic [7:0]       win_mem [WINDOW];

	logic [3:0]         state_q;
	logic [POS_W-1:0]   pos_q, idx_q, k_q;
	logic [SUM_W-1:0]   sum_q, best_q;
	logic               over_q, last_q, rep_q, clr_wr_q;
	logic [7:0]         ref_q, byte_q, old_q;
	logic [MATCH_W-1:0] match_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [CNT_W-1:0]   cnt_rd_q;
	logic [7:0]         win_rd_q;

	logic [7:0]         cnt_ra, cnt_wa;
	logic [CNT_W-1:0]   cnt_wd, c_new;
	logic               cnt_we, win_we, accept, m_hit;
	logic [SLOT_W-1:0]  win_ra, pos_slot;
	logic [POS_W-1:0]   last_k, pos_off;
	logic [SUM_W-1:0]   sum_new, sum_old;
	logic [MATCH_W-1:0] m_new;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);
	assign pos_off  = (pos_q >= WIN_P) ? pos_q - WIN_P : pos_q;
	assign pos_slot = pos_off[SLOT_W-1:0];
	assign last_k   = (idx_q >= WIN_P - 8'd1) ? WIN_P - 8'd1 : idx_q;
	assign m_hit    = (pos_q == REF_POS) ||
	                  (pos_q > REF_POS && pos_q < MATCH_END && data_byte == ref_q);
	assign m_new    = match_q + MATCH_W'(m_hit);
	assign c_new    = cnt_rd_q + CNT_W'(1);
	assign sum_new  = sum_q + SUM_W'({c_new, 1'b0}) - SUM_W'(1);
	assign sum_old  = sum_q - (SUM_W'({cnt_rd_q, 1'b0}) - SUM_W'(1));

	assign q_push = (state_q == ST_PUSH) && !q_full;
	assign q_data = '{short_pkt: (idx_q < WIN_P - 8'd1), repeat_run: rep_q, best: best_q};

	always_comb begin
		cnt_ra = byte_q;
		win_ra = slot_q;
		cnt_we = 1'b0;
		cnt_wa = byte_q;
		cnt_wd = '0;
		win_we = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				cnt_we = 1'b1;
				cnt_wa = k_q;
			end
			ST_IDLE: win_ra = pos_slot;
			ST_OLD1: cnt_ra = win_rd_q;
			ST_OLD2: begin
				cnt_we = 1'b1;
				cnt_wa = old_q;
				cnt_wd = cnt_rd_q - CNT_W'(1);
			end
			ST_NEW2: begin
				cnt_we = 1'b1;
				cnt_wd = c_new;
				win_we = 1'b1;
			end
			ST_CLR, ST_CLRW: begin
				win_ra = k_q[SLOT_W-1:0];
				cnt_we = clr_wr_q;
				cnt_wa = win_rd_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
		cnt_rd_q <= cnt_mem[cnt_ra];
		if (win_we) win_mem[slot_q] <= byte_q;
		win_rd_q <= win_mem[win_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_INIT;
			pos_q    <= '0;
			k_q      <= '0;
			sum_q    <= '0;
			best_q   <= '0;
			over_q   <= 1'b0;
			ref_q    <= '0;
			match_q  <= '0;
			rep_q    <= 1'b0;
			last_q   <= 1'b0;
			clr_wr_q <= 1'b0;
			idx_q    <= '0;
			slot_q   <= '0;
		end else begin
			clr_wr_q <= (state_q == ST_CLR);
			unique case (state_q)
				ST_INIT: begin
					k_q <= k_q + 8'd1;
					if (k_q == POS_MAX) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) begin
						byte_q <= data_byte;
						last_q <= last_byte;
						idx_q  <= pos_q;
						slot_q <= pos_slot;
						if (pos_q == REF_POS) ref_q <= data_byte;
						if (last_byte) begin
							rep_q   <= (m_new >= REPEAT_MIN);
							match_q <= '0;
							ref_q   <= '0;
							pos_q   <= '0;
						end else begin
							match_q <= m_new;
							if (pos_q != POS_MAX) pos_q <= pos_q + 8'd1;
						end
						if (pos_q < WIN_END)
							state_q <= (pos_q >= WIN_P) ? ST_OLD1 : ST_NEW1;
						else
							state_q <= last_byte ? ST_PUSH : ST_IDLE;
					end
				end
				ST_OLD1: begin
					old_q   <= win_rd_q;
					state_q <= ST_OLD2;
				end
				ST_OLD2: begin
					sum_q   <= sum_old;
					state_q <= ST_NEW1;
				end
				ST_NEW1: state_q <= ST_NEW2;
				ST_NEW2: begin
					sum_q <= sum_new;
					// first window over threshold is kept whole, later ones ignored
					if (idx_q >= WIN_P - 8'd1 && !over_q) begin
						if (sum_new > score_thr) begin
							over_q <= 1'b1;
							best_q <= sum_new;
						end else if (sum_new > best_q) begin
							best_q <= sum_new;
						end
					end
					state_q <= last_q ? ST_PUSH : ST_IDLE;
				end
				ST_PUSH: begin
					if (!q_full) begin
						sum_q   <= '0;
						best_q  <= '0;
						over_q  <= 1'b0;
						k_q     <= '0;
						state_q <= ST_CLR;
					end
				end
				ST_CLR: begin
					if (k_q == last_k) state_q <= ST_CLRW;
					else k_q <= k_q + 8'd1;
				end
				ST_CLRW: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- design/prbf_queue.sv -----
// prbf_queue: short summary queue between front and back.
// Depends on prbf_pkg.
module prbf_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  prbf_pkg::summary_t din,
	output logic               full,
	input  logic               pop,
	output prbf_pkg::summary_t dout,
	output logic               valid
);
	import prbf_pkg::*;

	summary_t           mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_q, rd_q;
	logic [QPTR_W:0]    cnt_q;

	assign full  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign valid = (cnt_q != '0);
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + QPTR_W'(1);
			if (pop)  rd_q <= rd_q + QPTR_W'(1);
			cnt_q <= cnt_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
		end
	end

endmodule

// ----- design/prbf_back.sv -----
// prbf_back: budget engine; sampling, drain division, refill and result register.
// Depends on prbf_pkg.
module prbf_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  prbf_pkg::cfg_t             cfg,
	input  logic                       q_valid,
	output logic                       q_pop,
	input  prbf_pkg::summary_t         q_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       anomalous,
	output logic [2:0]                 verdict,
	output logic [prbf_pkg::SUM_W-1:0] window_score,
	output logic [1:0]                 budget_level,
	output logic [31:0]                budget_value
);
	import prbf_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECIDE = 3'd1;
	localparam logic [2:0] ST_MOD    = 3'd2;
	localparam logic [2:0] ST_EVAL   = 3'd3;
	localparam logic [2:0] ST_MUL    = 3'd4;
	localparam logic [2:0] ST_DIV    = 3'd5;
	localparam logic [2:0] ST_DRAIN  = 3'd6;
	localparam logic [2:0] ST_FINISH = 3'd7;

	logic [2:0]          state_q;
	logic [31:0]         budget_q, samp_q, sh_q;
	logic [15:0]         run_q;
	summary_t            sum_q;
	logic                lvl0_q, insp_q, anom_q, load;
	logic [63-MOD_SHIFT:0] quo_q;
	logic [5:0]          cnt_q;
	logic [EX_W-1:0]     ex_q;
	logic [PROD_W-1:0]   prod_q;
	logic [SUM_W-1:0]    drem_q, score_q;
	logic [2:0]          verd_q;

	logic [1:0]        lvl;
	logic [31:0]       x_next;
	logic [63:0]       recip_prod;
	logic [31:0]       mod_rem;
	logic [SUM_W:0]    drem2, drem_sub;
	logic              ge;
	logic [32:0]       nb_short;
	logic [34:0]       amt;
	logic [35:0]       nb_clean;
	logic [15:0]       run_n;
	logic              bad;

	assign q_pop      = (state_q == ST_IDLE) && q_valid;
	assign lvl        = level_of(budget_q, cfg);
	assign x_next     = xorshift(samp_q);
	assign recip_prod = 64'(sh_q) * 64'(MOD_RECIP);
	assign mod_rem    = sh_q - 32'(quo_q) * 32'(MOD_BASE);
	assign drem2      = {drem_q, prod_q[PROD_W-1]};
	assign ge         = (drem2 >= {1'b0, cfg.score_thr});
	assign drem_sub   = drem2 - {1'b0, cfg.score_thr};
	assign nb_short   = {1'b0, budget_q} + {1'b0, cfg.refill};
	assign run_n      = (run_q == RUN_MAX) ? run_q : run_q + 16'd1;
	assign amt        = (run_n > cfg.streak_thr) ?
	                    35'({cfg.refill, 2'b00}) + 35'({cfg.refill, 1'b0}) : 35'(cfg.refill);
	assign nb_clean   = 36'(budget_q) + 36'(amt);
	assign bad        = insp_q && (sum_q.best > cfg.score_thr);
	assign load       = (state_q == ST_FINISH) && (!out_valid || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			budget_q  <= CFG_RST.ceiling;
			samp_q    <= SEED;
			run_q     <= '0;
			out_valid <= 1'b0;
			cnt_q     <= '0;
		end else begin
			if (load) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						sum_q   <= q_data;
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					score_q <= '0;
					if (sum_q.short_pkt) begin
						budget_q <= (nb_short > {1'b0, cfg.ceiling}) ?
						            cfg.ceiling : nb_short[31:0];
						verd_q   <= V_SHORT;
						anom_q   <= 1'b0;
						state_q  <= ST_FINISH;
					end else if (sum_q.repeat_run) begin
						budget_q <= (budget_q > cfg.penalty) ? budget_q - cfg.penalty : '0;
						verd_q   <= V_REPEAT;
						anom_q   <= 1'b1;
						state_q  <= ST_FINISH;
					end else if (lvl[1]) begin
						// constrained and quarantine always inspect
						insp_q  <= 1'b1;
						state_q <= ST_EVAL;
					end else begin
						samp_q  <= x_next;
						sh_q    <= x_next;
						cnt_q   <= '0;
						lvl0_q  <= (lvl == 2'd0);
						state_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					// x / 100 by reciprocal multiply, remainder on the next cycle
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd0) begin
						quo_q <= recip_prod[63:MOD_SHIFT];
					end else begin
						insp_q  <= mod_rem < 32'(lvl0_q ? RATE_LOW : RATE_HALF);
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (bad) begin
						run_q   <= '0;
						score_q <= sum_q.best;
						verd_q  <= V_ANOM;
						anom_q  <= 1'b1;
						if (cfg.score_thr == '0) begin
							budget_q <= '0;
							state_q  <= ST_FINISH;
						end else begin
							ex_q    <= EX_W'(sum_q.best - cfg.score_thr) * EX_W'(DRAIN_MUL);
							state_q <= ST_MUL;
						end
					end else begin
						run_q    <= run_n;
						budget_q <= (nb_clean > 36'(cfg.ceiling)) ?
						            cfg.ceiling : nb_clean[31:0];
						score_q  <= insp_q ? sum_q.best : '0;
						verd_q   <= insp_q ? V_CLEAN : V_SKIP;
						anom_q   <= 1'b0;
						state_q  <= ST_FINISH;
					end
				end
				ST_MUL: begin
					prod_q  <= PROD_W'(ex_q) * PROD_W'(cfg.penalty);
					drem_q  <= '0;
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					// restoring division, quotient shifts into prod_q
					drem_q <= ge ? drem_sub[SUM_W-1:0] : drem2[SUM_W-1:0];
					prod_q <= {prod_q[PROD_W-2:0], ge};
					cnt_q  <= cnt_q + 6'd1;
					if (cnt_q == 6'(PROD_W - 1)) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					budget_q <= (PROD_W'(budget_q) > prod_q) ? budget_q - prod_q[31:0] : '0;
					state_q  <= ST_FINISH;
				end
				ST_FINISH: begin
					if (load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			anomalous    <= anom_q;
			verdict      <= verd_q;
			window_score <= score_q;
			budget_level <= level_of(budget_q, cfg);
			budget_value <= budget_q;
		end
	end

endmodule

// ----- design/packet_repetition_budget_filter.sv -----
// packet_repetition_budget_filter: top level; configuration registers,
// front, summary queue, back. Depends on prbf_pkg, prbf_front, prbf_queue, prbf_back.
//
// Usage:
//  - Input channel (in_valid / in_stall): one packet byte per request, last_byte
//    on the final byte. Output channel (out_valid / out_stall): one verdict
//    request per packet, nothing for other bytes.
//  - Front work per byte: two histogram read-modify-writes at positions
//    WINDOW..WINDOW+15 (count memory with one read and one write port), one
//    below WINDOW, none past WINDOW+15. Packet end adds a queue push and a pass
//    over min(length, WINDOW) window slots zeroing the touched histogram entries.
//  - Back work per packet, from the pop: short and repeat packets go from the
//    decision to the result; others are evaluated, after the sampler mod-100
//    (reciprocal multiply) at levels 0/1; an anomalous packet with a nonzero
//    score threshold adds the drain multiply and 49-step serial division.
//    A two-entry queue lets front and back run apart.
//  - out_valid rises after the front tail, the back work and the result register.
//  - After reset the front zeros all 256 histogram entries with in_stall high;
//    configuration writes are taken at any time.
//  - When out_stall holds, the result stays in the output register, the back
//    waits with its next result, the queue fills and then in_stall rises.
//  - Configuration is written through cfg_we / cfg_index / cfg_data.
module packet_repetition_budget_filter #(
	parameter int WINDOW = prbf_pkg::WINDOW_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [7:0]                 data_byte,
	input  logic                       last_byte,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       anomalous,
	output logic [2:0]                 verdict,
	output logic [prbf_pkg::SUM_W-1:0] window_score,
	output logic [1:0]                 budget_level,
	output logic [31:0]                budget_value,
	input  logic                       cfg_we,
	input  logic [2:0]                 cfg_index,
	input  logic [31:0]                cfg_data
);
	import prbf_pkg::*;

	cfg_t     cfg_q;
	summary_t push_data, pop_data;
	logic     q_push, q_full, q_pop, q_valid;

	// register file; narrow registers keep their low bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				R_LVL1:    cfg_q.lvl1       <= cfg_data;
				R_LVL2:    cfg_q.lvl2       <= cfg_data;
				R_LVL3:    cfg_q.lvl3       <= cfg_data;
				R_CEIL:    cfg_q.ceiling    <= cfg_data;
				R_REFILL:  cfg_q.refill     <= cfg_data;
				R_PENALTY: cfg_q.penalty    <= cfg_data;
				R_SCORE:   cfg_q.score_thr  <= cfg_data[SUM_W-1:0];
				R_STREAK:  cfg_q.streak_thr <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// byte intake and per-packet statistics
	prbf_front #(.WINDOW(WINDOW)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.score_thr (cfg_q.score_thr),
		.q_push    (q_push),
		.q_data    (push_data),
		.q_full    (q_full)
	);

	prbf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (push_data),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (pop_data),
		.valid  (q_valid)
	);

	// budget update and verdict
	prbf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_valid      (q_valid),
		.q_pop        (q_pop),
		.q_data       (pop_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.anomalous    (anomalous),
		.verdict      (verdict),
		.window_score (window_score),
		.budget_level (budget_level),
		.budget_value (budget_value)
	);

	// anomalous flag agrees with the verdict code
	a_anom_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (anomalous == (verdict == V_REPEAT || verdict == V_ANOM)))
		else $error("anomalous flag disagrees with verdict");

	// uninspected packets report no score
	a_no_score: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (verdict == V_SHORT || verdict == V_REPEAT || verdict == V_SKIP)
		|-> (window_score == '0))
		else $error("score reported for uninspected packet");

	// reported level matches reported budget
	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (budget_level == level_of(budget_value, cfg_q)))
		else $error("budget level does not match budget value");

	// queue never takes a summary while full
	a_queue: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_push)
		else $error("summary pushed into full queue");

endmodule

// ----- verif/packet_repetition_budget_filter_test.sv -----
// Self-checking testbench for packet_repetition_budget_filter: drives packet bytes,
// predicts each per-packet verdict and budget update, and compares all output fields.
// Depends on prbf_pkg and the packet_repetition_budget_filter RTL.
`timescale 1ns / 100ps

module packet_repetition_budget_filter_test;
	import prbf_pkg::*;

	typedef struct packed {
		logic             anom;
		logic [2:0]       verd;
		logic [SUM_W-1:0] score;
		logic [1:0]       lvl;
		logic [31:0]      budget;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic [7:0] data_byte = '0;
	logic last_byte = 1'b0;
	logic out_stall = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic in_stall, out_valid, anomalous;
	logic [2:0] verdict;
	logic [SUM_W-1:0] window_score;
	logic [1:0] budget_level;
	logic [31:0] budget_value;

	packet_repetition_budget_filter DUT (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// shadow copy of the block's configuration and state
	cfg_t        shadow_cfg;
	logic [31:0] budget_q;
	logic [31:0] sampler_q;
	logic [15:0] clean_run_q;
	int          pos_q;
	int          hist[256];
	logic [7:0]  win_bytes[64];
	int          win_sum, best_sum;
	bit          over_q;
	logic [7:0]  ref_byte;
	int          match_cnt;

	verdict_t expected_verdicts[$];
	int  mismatches = 0;
	int  send_idle_pct = 0;
	int  stall_pct = 0;
	longint cycles = 0;

	function automatic logic [1:0] budget_level_of(logic [31:0] b);
		if (b > shadow_cfg.lvl1) return 2'd0;
		if (b > shadow_cfg.lvl2) return 2'd1;
		if (b > shadow_cfg.lvl3) return 2'd2;
		return 2'd3;
	endfunction

	function automatic void add_budget(logic [63:0] amt);
		logic [63:0] nb;
		nb = {32'd0, budget_q} + amt;
		budget_q = (nb > {32'd0, shadow_cfg.ceiling}) ? shadow_cfg.ceiling : nb[31:0];
	endfunction

	function automatic void take_budget(logic [63:0] amt);
		budget_q = ({32'd0, budget_q} > amt) ? budget_q - amt[31:0] : 32'd0;
	endfunction

	function automatic void clear_packet_state();
		foreach (hist[k]) hist[k] = 0;
		win_sum = 0;
		best_sum = 0;
		over_q = 0;
		ref_byte = '0;
		match_cnt = 0;
		pos_q = 0;
	endfunction

	// per-byte update; pushes a verdict on the final byte of a packet
	function automatic void predict_byte(logic [7:0] b, logic last);
		int i, slot, c;
		logic [1:0] lvl;
		bit inspect;
		logic [31:0] rnd;
		logic [63:0] drain_amt;
		verdict_t v;
		i = pos_q;
		if (i < WINDOW_DEF + TAIL_LEN) begin
			slot = i % WINDOW_DEF;
			if (i >= WINDOW_DEF) begin
				c = hist[win_bytes[slot]];
				win_sum -= 2 * c - 1;
				hist[win_bytes[slot]] = c - 1;
			end
			win_bytes[slot] = b;
			hist[b] += 1;
			win_sum += 2 * hist[b] - 1;
			if (i + 1 >= WINDOW_DEF && !over_q) begin
				if (win_sum > shadow_cfg.score_thr) begin
					over_q = 1;
					best_sum = win_sum;
				end else if (win_sum > best_sum) begin
					best_sum = win_sum;
				end
			end
		end
		if (i == 64) ref_byte = b;
		if (i >= 64 && i < 80 && b == ref_byte) match_cnt++;
		if (pos_q < 255) pos_q++;
		if (!last) return;
		v = '0;
		if (i + 1 < WINDOW_DEF) begin
			add_budget({32'd0, shadow_cfg.refill});
			v.verd = V_SHORT;
		end else if (match_cnt >= 14) begin
			take_budget({32'd0, shadow_cfg.penalty});
			v.verd = V_REPEAT;
			v.anom = 1'b1;
		end else begin
			lvl = budget_level_of(budget_q);
			inspect = 1;
			if (lvl < 2) begin
				rnd = sampler_q ^ (sampler_q << 13);
				rnd = rnd ^ (rnd >> 17);
				rnd = rnd ^ (rnd << 5);
				sampler_q = rnd;
				inspect = (rnd % 100) < ((lvl == 0) ? 5 : 50);
			end
			if (inspect) v.score = best_sum;
			if (inspect && v.score > shadow_cfg.score_thr) begin
				clean_run_q = '0;
				if (shadow_cfg.score_thr == 0) drain_amt = 64'(budget_q);
				else drain_amt = (64'(v.score - shadow_cfg.score_thr) * shadow_cfg.penalty
					* 10) / shadow_cfg.score_thr;
				take_budget(drain_amt);
				v.verd = V_ANOM;
				v.anom = 1'b1;
			end else begin
				if (clean_run_q != 16'hFFFF) clean_run_q++;
				if (clean_run_q > shadow_cfg.streak_thr)
					add_budget(64'(shadow_cfg.refill) * 6);
				else
					add_budget({32'd0, shadow_cfg.refill});
				v.verd = inspect ? V_CLEAN : V_SKIP;
			end
		end
		v.lvl = budget_level_of(budget_q);
		v.budget = budget_q;
		expected_verdicts.push_back(v);
		clear_packet_state();
	endfunction

	// result checker and receiver stall
	always @(posedge clk) begin
		verdict_t got, want;
		cycles <= cycles + 1;
		if (arst_n && out_valid && !out_stall) begin
			got = '{anomalous, verdict, window_score, budget_level, budget_value};
			if (expected_verdicts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected verdict: got %p", got);
			end else begin
				want = expected_verdicts.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("verdict mismatch: expected %p got %p", want, got);
				end
			end
		end
		out_stall <= ($urandom_range(99) < stall_pct);
		if (cycles > 3000000) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// one byte request; holds until accepted, valid stays up for the next byte
	task automatic send_byte(logic [7:0] b, logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= last;
		predict_byte(b, last);
		do @(posedge clk); while (in_stall);
	endtask

	// fill: 0 random, 1 constant, 2 small alphabet
	task automatic send_packet(int len, int fill);
		logic [7:0] k;
		k = 8'($urandom);
		for (int n = 0; n < len; n++) begin
			case (fill)
				0: send_byte(8'($urandom), n == len - 1);
				1: send_byte(k, n == len - 1);
				default: send_byte(8'(k + $urandom_range(3)), n == len - 1);
			endcase
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_verdicts.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			R_LVL1:    shadow_cfg.lvl1 = val;
			R_LVL2:    shadow_cfg.lvl2 = val;
			R_LVL3:    shadow_cfg.lvl3 = val;
			R_CEIL:    shadow_cfg.ceiling = val;
			R_REFILL:  shadow_cfg.refill = val;
			R_PENALTY: shadow_cfg.penalty = val;
			R_SCORE:   shadow_cfg.score_thr = val[SUM_W-1:0];
			default:   shadow_cfg.streak_thr = val[15:0];
		endcase
		@(posedge clk);
	endtask

	// short packets, boundary lengths, repeat runs, near-repeat runs, long packets
	task automatic test_directed();
		send_packet(1, 0);
		send_packet(63, 0);
		send_packet(64, 1);
		send_packet(65, 1);
		send_packet(79, 1);
		send_packet(80, 1);
		send_packet(300, 2);
		for (int n = 0; n < 2; n++) send_packet(80, 2);
		send_byte(8'hFF, 1'b0);
		send_packet(70, 1);
		send_byte(8'h00, 1'b1);
		drain_results();
	endtask

	// repeat runs and high-repetition packets drain to quarantine
	task automatic test_drain_levels();
		write_reg(R_SCORE, 32'd1);
		write_reg(R_PENALTY, 32'hFFFF_FFFF);
		for (int n = 0; n < 2; n++) send_packet(80 + $urandom_range(20), 1);
		drain_results();
		write_reg(R_SCORE, 32'h0000_E000);
		for (int n = 0; n < 2; n++) send_packet(64 + $urandom_range(30), 2);
		drain_results();
	endtask

	task automatic test_random(int packets, int idle_pct, int stall);
		int len;
		send_idle_pct = idle_pct;
		stall_pct = stall;
		for (int n = 0; n < packets; n++) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(1, 63) : $urandom_range(64, 90);
			if ($urandom_range(40) == 0) len = $urandom_range(200, 270);
			send_packet(len, $urandom_range(2));
		end
		drain_results();
		send_idle_pct = 0;
		stall_pct = 0;
	endtask

	task automatic test_settings();
		write_reg(R_LVL1, 32'hFFFF_FFFF);
		write_reg(R_LVL2, 32'h0006_0000);
		write_reg(R_LVL3, 32'd0);
		write_reg(R_CEIL, 32'h0008_0000);
		write_reg(R_REFILL, 32'hFFFF_FFFF);
		write_reg(R_PENALTY, 32'h0001_0000);
		write_reg(R_SCORE, 32'd4096);
		write_reg(R_STREAK, 32'd0);
		test_random(1, 20, 20);
		write_reg(R_SCORE, 32'd64);
		write_reg(R_STREAK, 32'hFFFF);
		write_reg(R_REFILL, 32'd0);
		test_random(1, 20, 20);
		write_reg(R_LVL1, 32'd4915200);
		write_reg(R_LVL2, 32'd3276800);
		write_reg(R_LVL3, 32'd1638400);
		write_reg(R_CEIL, 32'd6553600);
		write_reg(R_REFILL, 32'd65536);
		write_reg(R_PENALTY, 32'd327680);
		write_reg(R_SCORE, 32'd300);
		write_reg(R_STREAK, 32'd3);
	endtask

	initial begin
		shadow_cfg = CFG_RST;
		budget_q = CFG_RST.ceiling;
		sampler_q = SEED;
		clean_run_q = '0;
		foreach (win_bytes[k]) win_bytes[k] = '0;
		clear_packet_state();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_drain_levels();
		test_settings();
		test_random(2, 0, 0);
		test_random(2, 55, 0);
		test_random(2, 0, 55);
		test_random(2, 13, 13);
		if (mismatches == 0 && expected_verdicts.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- packet_repetition_budget_filter.f -----
design/prbf_pkg.sv
design/prbf_front.sv
design/prbf_queue.sv
design/prbf_back.sv
design/packet_repetition_budget_filter.sv
verif/packet_repetition_budget_filter_test.sv
